[rtl/fsp_pkg.sv]
package fsp_pkg;

    // Bit count of the saturation limit for decimal digits, clamped to 8..32.
    localparam int VALUE_BITS  = 32;
    localparam int LIM_BITS_LO = (VALUE_BITS < 8) ? 8 : VALUE_BITS;
    localparam int LIM_BITS    = (LIM_BITS_LO > 32) ? 32 : LIM_BITS_LO;

    localparam int ACC_W = 32;
    // acc * 10 + 9 fits in four more bits than the accumulator.
    localparam int SUM_W = ACC_W + 4;
    localparam logic [SUM_W-1:0] DIGIT_LIMIT =
        SUM_W'((64'd1 << (LIM_BITS - 1)) - 64'd1);
    localparam logic [ACC_W-1:0] NO_VALUE = '1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_P     = 8'h70;

    typedef logic [3:0] t_conv;
    localparam t_conv CONV_C       = 4'd0;
    localparam t_conv CONV_S       = 4'd1;
    localparam t_conv CONV_LHEX    = 4'd2;
    localparam t_conv CONV_UHEX    = 4'd3;
    localparam t_conv CONV_DEC     = 4'd4;
    localparam t_conv CONV_PCT     = 4'd5;
    localparam t_conv CONV_UNS     = 4'd6;
    localparam t_conv CONV_PTR     = 4'd7;
    localparam t_conv CONV_NUL_ERR = 4'd8;
    localparam t_conv CONV_UNKNOWN = 4'd9;

    localparam logic [1:0] PAD_SPACE = 2'd0;
    localparam logic [1:0] PAD_ZERO  = 2'd1;
    localparam logic [1:0] PAD_LEFT  = 2'd2;

    localparam logic [1:0] SIGN_NONE  = 2'd0;
    localparam logic [1:0] SIGN_PLUS  = 2'd1;
    localparam logic [1:0] SIGN_SPACE = 2'd2;

endpackage

[rtl/format_specifier_parser_top.sv]
// Format specifier parser.
// Input channel: i_in_valid / o_in_ready carry one item, the character after
// a percent sign (i_ch) plus the next integer argument (i_star_arg), which is
// used only when the character is a star. Output channel: o_out_valid /
// i_out_ready carry one decoded specifier, produced on the conversion
// character, a NUL or an unknown character; other characters give no result.
// An item is taken into an input register, decoded against the parse state by
// one stage of logic, and its result lands in an output register. One item per
// cycle is sustained while the output register is free or being drained; the
// rate rests on the state update (phase plus a multiply-by-ten digit accumulate)
// being done within the decode stage.
// When the receiver stalls, the result holds in the output register and the
// input register still takes one more item if it is empty; the decode stage waits
// only when the output register is full and not being drained.
// Reset (synchronous, active low) empties both registers and returns the
// parser to the flag phase with all partial fields cleared.
module format_specifier_parser_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_ch,
    input  logic signed [31:0] i_star_arg,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [3:0]         o_conv_code,
    output logic [1:0]         o_pad_mode,
    output logic [1:0]         o_sign_mode,
    output logic               o_alt_form,
    output logic signed [31:0] o_field_width,
    output logic signed [31:0] o_precision_value
);

    localparam int ACC_W = fsp_pkg::ACC_W;
    localparam int SUM_W = fsp_pkg::SUM_W;

    localparam logic [2:0] PH_FLAGS   = 3'd0;
    localparam logic [2:0] PH_WDIG    = 3'd1;
    localparam logic [2:0] PH_AFTER_W = 3'd2;
    localparam logic [2:0] PH_DOT     = 3'd3;
    localparam logic [2:0] PH_PDIG    = 3'd4;
    localparam logic [2:0] PH_AFTER_P = 3'd5;

    // Input register.
    logic             r_in_vld;
    logic [7:0]       r_ch;
    logic [ACC_W-1:0] r_star;

    // Parse state.
    logic [2:0]       r_phase, n_phase;
    logic [1:0]       r_pad, n_pad;
    logic [1:0]       r_sign, n_sign;
    logic             r_alt, n_alt;
    logic [ACC_W-1:0] r_width, n_width;
    logic [ACC_W-1:0] r_prec, n_prec;

    // Output register.
    logic             r_out_vld;
    fsp_pkg::t_conv   r_conv, n_conv;
    logic [1:0]       r_opad, n_opad;
    logic [1:0]       r_osign, n_osign;
    logic             r_oalt, n_oalt;
    logic [ACC_W-1:0] r_owidth, n_owidth;
    logic [ACC_W-1:0] r_oprec, n_oprec;

    logic             out_free;
    logic             fire;
    logic             fin;
    logic [2:0]       ph;
    logic             is_dig;
    logic [ACC_W-1:0] acc_src;
    logic [SUM_W-1:0] acc_sum;
    logic [ACC_W-1:0] acc_res;

    assign out_free   = !r_out_vld || i_out_ready;
    assign fire       = r_in_vld && out_free;
    assign o_in_ready = !r_in_vld || fire;

    assign ph     = (r_phase > PH_AFTER_P) ? PH_FLAGS : r_phase;
    assign is_dig = (r_ch >= fsp_pkg::CH_ZERO) && (r_ch <= fsp_pkg::CH_NINE);

    // Saturating acc * 10 + digit; a fresh digit run starts from zero.
    always_comb begin
        if (ph == PH_WDIG) begin
            acc_src = r_width;
        end else if (ph == PH_PDIG) begin
            acc_src = r_prec;
        end else begin
            acc_src = '0;
        end
        acc_sum = {1'b0, acc_src, 3'b000} + {3'b000, acc_src, 1'b0}
                + SUM_W'(r_ch[3:0] - fsp_pkg::CH_ZERO[3:0]);
        if (acc_sum > fsp_pkg::DIGIT_LIMIT) begin
            acc_res = ACC_W'(fsp_pkg::DIGIT_LIMIT);
        end else begin
            acc_res = acc_sum[ACC_W-1:0];
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_pad   = r_pad;
        n_sign  = r_sign;
        n_alt   = r_alt;
        n_width = r_width;
        n_prec  = r_prec;
        fin     = 1'b0;
        case (ph)
            PH_FLAGS: begin
                if (r_ch == fsp_pkg::CH_MINUS) begin
                    n_pad = fsp_pkg::PAD_LEFT;
                end else if (r_ch == fsp_pkg::CH_PLUS) begin
                    n_sign = fsp_pkg::SIGN_PLUS;
                end else if (r_ch == fsp_pkg::CH_SPACE) begin
                    if (r_sign == fsp_pkg::SIGN_NONE) begin
                        n_sign = fsp_pkg::SIGN_SPACE;
                    end
                end else if (r_ch == fsp_pkg::CH_HASH) begin
                    n_alt = 1'b1;
                end else if (r_ch == fsp_pkg::CH_ZERO && r_pad == fsp_pkg::PAD_SPACE) begin
                    n_pad = fsp_pkg::PAD_ZERO;
                end else if (r_ch == fsp_pkg::CH_STAR) begin
                    n_width = r_star;
                    n_phase = PH_AFTER_W;
                end else if (is_dig) begin
                    n_width = acc_res;
                    n_phase = PH_WDIG;
                end else if (r_ch == fsp_pkg::CH_DOT) begin
                    n_prec  = '0;
                    n_phase = PH_DOT;
                end else begin
                    fin = 1'b1;
                end
            end
            PH_WDIG: begin
                if (is_dig) begin
                    n_width = acc_res;
                end else if (r_ch == fsp_pkg::CH_DOT) begin
                    n_prec  = '0;
                    n_phase = PH_DOT;
                end else begin
                    fin = 1'b1;
                end
            end
            PH_AFTER_W: begin
                if (r_ch == fsp_pkg::CH_DOT) begin
                    n_prec  = '0;
                    n_phase = PH_DOT;
                end else begin
                    fin = 1'b1;
                end
            end
            PH_DOT: begin
                if (r_ch == fsp_pkg::CH_STAR) begin
                    n_prec  = r_star;
                    n_phase = PH_AFTER_P;
                end else if (is_dig) begin
                    n_prec  = acc_res;
                    n_phase = PH_PDIG;
                end else begin
                    fin = 1'b1;
                end
            end
            PH_PDIG: begin
                if (is_dig) begin
                    n_prec = acc_res;
                end else begin
                    fin = 1'b1;
                end
            end
            default: begin
                fin = 1'b1;
            end
        endcase
        // Every result starts a fresh specifier.
        if (fin) begin
            n_phase = PH_FLAGS;
            n_pad   = fsp_pkg::PAD_SPACE;
            n_sign  = fsp_pkg::SIGN_NONE;
            n_alt   = 1'b0;
            n_width = fsp_pkg::NO_VALUE;
            n_prec  = fsp_pkg::NO_VALUE;
        end
    end

    // Result fields for a terminating character.
    always_comb begin
        logic full;
        logic keep_sign;
        full      = 1'b1;
        keep_sign = 1'b1;
        case (r_ch)
            fsp_pkg::CH_NUL: begin
                n_conv = fsp_pkg::CONV_NUL_ERR;
                full   = 1'b0;
            end
            fsp_pkg::CH_C:  n_conv = fsp_pkg::CONV_C;
            fsp_pkg::CH_S:  n_conv = fsp_pkg::CONV_S;
            fsp_pkg::CH_LX: begin
                n_conv    = fsp_pkg::CONV_LHEX;
                keep_sign = 1'b0;
            end
            fsp_pkg::CH_UX: begin
                n_conv    = fsp_pkg::CONV_UHEX;
                keep_sign = 1'b0;
            end
            fsp_pkg::CH_D:  n_conv = fsp_pkg::CONV_DEC;
            fsp_pkg::CH_I:  n_conv = fsp_pkg::CONV_DEC;
            fsp_pkg::CH_PCT: begin
                n_conv = fsp_pkg::CONV_PCT;
                full   = 1'b0;
            end
            fsp_pkg::CH_U: begin
                n_conv    = fsp_pkg::CONV_UNS;
                keep_sign = 1'b0;
            end
            fsp_pkg::CH_P:  n_conv = fsp_pkg::CONV_PTR;
            default: begin
                n_conv = fsp_pkg::CONV_UNKNOWN;
                full   = 1'b0;
            end
        endcase
        n_opad   = full ? r_pad : fsp_pkg::PAD_SPACE;
        n_osign  = (full && keep_sign) ? r_sign : fsp_pkg::SIGN_NONE;
        n_oalt   = full ? r_alt : 1'b0;
        n_owidth = full ? r_width : fsp_pkg::NO_VALUE;
        n_oprec  = full ? r_prec : fsp_pkg::NO_VALUE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_ch   <= i_ch;
            r_star <= i_star_arg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FLAGS;
            r_pad   <= fsp_pkg::PAD_SPACE;
            r_sign  <= fsp_pkg::SIGN_NONE;
            r_alt   <= 1'b0;
            r_width <= fsp_pkg::NO_VALUE;
            r_prec  <= fsp_pkg::NO_VALUE;
        end else if (fire) begin
            r_phase <= n_phase;
            r_pad   <= n_pad;
            r_sign  <= n_sign;
            r_alt   <= n_alt;
            r_width <= n_width;
            r_prec  <= n_prec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire && fin) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && fin) begin
            r_conv   <= n_conv;
            r_opad   <= n_opad;
            r_osign  <= n_osign;
            r_oalt   <= n_oalt;
            r_owidth <= n_owidth;
            r_oprec  <= n_oprec;
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_conv_code       = r_conv;
    assign o_pad_mode        = r_opad;
    assign o_sign_mode       = r_osign;
    assign o_alt_form        = r_oalt;
    assign o_field_width     = $signed(r_owidth);
    assign o_precision_value = $signed(r_oprec);

endmodule
